// ===== rtl/pcts_pkg.sv =====
`timescale 1ns / 1ps
// Package for the percent substitution pass: payload word types, character
// codes and configuration register indexes. No dependencies.
package pcts_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       string_end;
  } out_word_t;

  // output queue depth, a power of two of at least two
  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic CFG_DIALECT  = 1'b0;
  localparam logic CFG_EVALUATE = 1'b1;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UP_B    = 8'h42;
  localparam logic [7:0] CH_UP_C    = 8'h43;
  localparam logic [7:0] CH_UP_I    = 8'h49;
  localparam logic [7:0] CH_UP_L    = 8'h4C;
  localparam logic [7:0] CH_UP_Q    = 8'h51;
  localparam logic [7:0] CH_UP_R    = 8'h52;
  localparam logic [7:0] CH_UP_T    = 8'h54;
  localparam logic [7:0] CH_UP_V    = 8'h56;
  localparam logic [7:0] CH_UP_W    = 8'h57;
  localparam logic [7:0] CH_UP_X    = 8'h58;

endpackage

// ===== rtl/percent_substitution_pass.sv =====
`timescale 1ns / 1ps
// Top level of the percent substitution pass: scanner state machine and
// output queue. Depends on pcts_pkg.

// One input byte is taken per cycle while in_stall is low. Each byte is
// decoded in the cycle it is accepted and yields zero, one or two output
// words, which go into a four-word output queue; the queue drains one word
// per cycle while out_stall is low, so bytes that expand to two words (CR LF,
// "% ") can fill the queue and hold the input. in_stall rises while fewer
// than two queue slots are free. Configuration writes take effect on the next
// accepted byte and should be made while no string is in flight.
module percent_substitution_pass (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcts_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pcts_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data
);

  localparam int PtrW = $clog2(pcts_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(pcts_pkg::QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_PLAIN      = 4'd0,
    ST_ESC        = 4'd1,
    ST_PCT        = 4'd2,
    ST_ANGLE_OPT  = 4'd3,
    ST_ARG        = 4'd4,
    ST_ANGLE      = 4'd5,
    ST_ALPHA_OPT  = 4'd6,
    ST_I_OPT      = 4'd7,
    ST_DOLLAR_OPT = 4'd8
  } scan_t;

  scan_t scan_state, scan_state_next;
  logic  dialect, evaluate_mode;

  pcts_pkg::out_word_t queue [pcts_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     count, count_next;

  logic       accept, pop;
  logic [7:0] c, up, ch0, ch1;
  logic [1:0] n_emit, n_push;
  logic       fin, second, ev, is_alpha, is_digit, tail, plain;
  pcts_pkg::out_word_t w0, w1;

  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  always_comb begin
    c        = in_word.char_in;
    fin      = in_word.is_final;
    second   = dialect;
    ev       = evaluate_mode;
    is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    is_digit = (c >= 8'h30 && c <= 8'h39);
    up       = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    n_emit   = 2'd0;
    ch0      = c;
    ch1      = c;
    tail     = 1'b0;
    plain    = 1'b0;
    scan_state_next = scan_state;

    case (scan_state)
      ST_ESC: begin
        n_emit = 2'd1;
        scan_state_next = ST_PLAIN;
      end
      ST_PCT: begin
        // value byte of the unit
        n_emit = 2'd1;
        if (!ev) begin
          ch0 = c;
        end else if (c == pcts_pkg::CH_PERCENT) begin
          ch0 = pcts_pkg::CH_PERCENT;
        end else if (up == pcts_pkg::CH_UP_B) begin
          ch0 = pcts_pkg::CH_SPACE;
        end else if (up == pcts_pkg::CH_UP_T) begin
          ch0 = pcts_pkg::CH_TAB;
        end else if (up == pcts_pkg::CH_UP_R) begin
          if (second) begin
            ch0 = pcts_pkg::CH_LF;
          end else begin
            n_emit = 2'd2;
            ch0    = pcts_pkg::CH_CR;
            ch1    = pcts_pkg::CH_LF;
          end
        end else if (second && c == pcts_pkg::CH_SPACE) begin
          n_emit = 2'd2;
          ch0    = pcts_pkg::CH_PERCENT;
          ch1    = pcts_pkg::CH_SPACE;
        end

        if (second && c == pcts_pkg::CH_SPACE) begin
          scan_state_next = ST_PLAIN;
        end else if (is_digit) begin
          scan_state_next = ST_PLAIN;
        end else if (up == pcts_pkg::CH_UP_Q) begin
          scan_state_next = ST_ARG;
        end else if (up == pcts_pkg::CH_UP_V) begin
          scan_state_next = ST_ALPHA_OPT;
        end else if (second && up == pcts_pkg::CH_UP_W) begin
          scan_state_next = ST_ALPHA_OPT;
        end else if (up == pcts_pkg::CH_UP_C || up == pcts_pkg::CH_UP_X) begin
          if (second) begin
            scan_state_next = (up == pcts_pkg::CH_UP_X) ? ST_ALPHA_OPT : ST_PLAIN;
          end else begin
            scan_state_next = ST_ARG;
          end
        end else if (c == pcts_pkg::CH_EQ) begin
          scan_state_next = ST_ANGLE_OPT;
        end else if (up == pcts_pkg::CH_UP_I) begin
          scan_state_next = ST_I_OPT;
        end else if (second && c == pcts_pkg::CH_DOLLAR) begin
          scan_state_next = ST_DOLLAR_OPT;
        end else begin
          scan_state_next = ST_PLAIN;
        end
      end
      ST_ANGLE_OPT: begin
        if (c == pcts_pkg::CH_LT) begin
          tail = 1'b1;
          scan_state_next = ST_ANGLE;
        end else begin
          plain = 1'b1;
        end
      end
      ST_ARG: begin
        tail = 1'b1;
        scan_state_next = (c == pcts_pkg::CH_LT) ? ST_ANGLE : ST_PLAIN;
      end
      ST_ANGLE: begin
        tail = 1'b1;
        scan_state_next = (c == pcts_pkg::CH_GT) ? ST_PLAIN : ST_ANGLE;
      end
      ST_ALPHA_OPT: begin
        if (is_alpha) begin
          tail = 1'b1;
          scan_state_next = ST_PLAIN;
        end else begin
          plain = 1'b1;
        end
      end
      ST_I_OPT: begin
        if (is_digit || (second && up == pcts_pkg::CH_UP_L)) begin
          tail = 1'b1;
          scan_state_next = ST_PLAIN;
        end else begin
          plain = 1'b1;
        end
      end
      ST_DOLLAR_OPT: begin
        if (is_digit || up == pcts_pkg::CH_UP_L) begin
          tail = 1'b1;
          scan_state_next = ST_PLAIN;
        end else begin
          plain = 1'b1;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    // trailing unit bytes show only when copying verbatim
    if (tail && !ev) begin
      n_emit = 2'd1;
    end

    if (plain) begin
      if (c == pcts_pkg::CH_BSLASH) begin
        scan_state_next = ST_ESC;
      end else if (c == pcts_pkg::CH_PERCENT) begin
        if (!ev || fin) begin
          n_emit = 2'd1;
        end
        scan_state_next = ST_PCT;
      end else begin
        n_emit = 2'd1;
        scan_state_next = ST_PLAIN;
      end
    end

    if (fin) begin
      scan_state_next = ST_PLAIN;
    end

    w0.char_out   = ch0;
    w0.char_valid = 1'b1;
    w0.string_end = fin && (n_emit == 2'd1);
    w1.char_out   = ch1;
    w1.char_valid = 1'b1;
    w1.string_end = fin;
    n_push        = n_emit;
    // bare end marker
    if (fin && n_emit == 2'd0) begin
      w0.char_out   = 8'h00;
      w0.char_valid = 1'b0;
      w0.string_end = 1'b1;
      n_push        = 2'd1;
    end
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      count_next = count_next + CntW'(n_push);
    end
    if (pop) begin
      count_next = count_next - CntW'(1);
    end
  end

  assign in_stall  = (count > CntW'(pcts_pkg::QUEUE_DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_word  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state    <= ST_PLAIN;
      dialect       <= 1'b0;
      evaluate_mode <= 1'b1;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pcts_pkg::CFG_DIALECT:  dialect       <= cfg_data;
          pcts_pkg::CFG_EVALUATE: evaluate_mode <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        scan_state <= scan_state_next;
        if (n_push != 2'd0) begin
          queue[wr_ptr] <= w0;
        end
        if (n_push == 2'd2) begin
          queue[wr_ptr + PtrW'(1)] <= w1;
        end
        wr_ptr <= wr_ptr + PtrW'(n_push);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count_next;
    end
  end

endmodule

// ===== rtl/pcts_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the percent substitution pass, bound to the top
// level. Depends on pcts_pkg and percent_substitution_pass.
module pcts_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input pcts_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_stall,
  input pcts_pkg::out_word_t out_word
);

  // an empty output side never holds off input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output queue");

  // a final byte always produces at least one word
  a_final_produces: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_word.is_final) |=> out_valid)
    else $error("final byte produced no word");

  // a bare marker only closes a string
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.char_valid) |-> (out_word.string_end && out_word.char_out == 8'h00))
    else $error("bare marker without string end");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled output word changed");

endmodule

bind percent_substitution_pass pcts_checker u_pcts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== tb/percent_substitution_checker.sv =====
`timescale 1ns / 1ps
// Checker for the percent substitution pass: follows the input, output and
// config ports, predicts every output word and compares. Depends on pcts_pkg.
module percent_substitution_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pcts_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pcts_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_data,
  output int                  errors,
  output int                  waiting
);

  typedef enum logic [3:0] {
    SC_PLAIN,
    SC_ESC,
    SC_PCT,
    SC_ANGLE_OPT,
    SC_ARG,
    SC_ANGLE,
    SC_ALPHA_OPT,
    SC_I_OPT,
    SC_DOLLAR_OPT
  } scan_t;

  scan_t               scan_q = SC_PLAIN;
  logic                dialect_q = 1'b0;
  logic                eval_q = 1'b1;
  logic [7:0]          emitted [2];
  int                  n_emit;
  int                  mismatch_cnt = 0;
  pcts_pkg::out_word_t expected_words [$];

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic void queue_word(pcts_pkg::out_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void emit_char(logic [7:0] c);
    if (n_emit < 2) begin
      emitted[n_emit] = c;
      n_emit++;
    end
  endfunction

  // bytes of a unit past its value byte only show up when copying verbatim
  function automatic void unit_tail(logic [7:0] c);
    if (!eval_q) emit_char(c);
  endfunction

  function automatic void plain_text(logic [7:0] c, logic fin);
    if (c == pcts_pkg::CH_BSLASH) begin
      scan_q = SC_ESC;
    end else if (c == pcts_pkg::CH_PERCENT) begin
      if (!eval_q || fin) emit_char(pcts_pkg::CH_PERCENT);
      scan_q = SC_PCT;
    end else begin
      emit_char(c);
      scan_q = SC_PLAIN;
    end
  endfunction

  function automatic void unit_head(logic [7:0] c);
    logic       second;
    logic [7:0] up;
    second = dialect_q;
    up = upcase(c);
    if (!eval_q) emit_char(c);
    else if (c == pcts_pkg::CH_PERCENT) emit_char(pcts_pkg::CH_PERCENT);
    else if (up == pcts_pkg::CH_UP_B) emit_char(pcts_pkg::CH_SPACE);
    else if (up == pcts_pkg::CH_UP_T) emit_char(pcts_pkg::CH_TAB);
    else if (up == pcts_pkg::CH_UP_R) begin
      if (!second) emit_char(pcts_pkg::CH_CR);
      emit_char(pcts_pkg::CH_LF);
    end else if (second && c == pcts_pkg::CH_SPACE) begin
      emit_char(pcts_pkg::CH_PERCENT);
      emit_char(pcts_pkg::CH_SPACE);
    end else emit_char(c);

    if ((second && c == pcts_pkg::CH_SPACE) || is_num(c)) scan_q = SC_PLAIN;
    else if (up == pcts_pkg::CH_UP_Q) scan_q = SC_ARG;
    else if (up == pcts_pkg::CH_UP_V || (second && up == pcts_pkg::CH_UP_W))
      scan_q = SC_ALPHA_OPT;
    else if (up == pcts_pkg::CH_UP_C || up == pcts_pkg::CH_UP_X) begin
      if (!second) scan_q = SC_ARG;
      else if (up == pcts_pkg::CH_UP_X) scan_q = SC_ALPHA_OPT;
      else scan_q = SC_PLAIN;
    end else if (c == pcts_pkg::CH_EQ) scan_q = SC_ANGLE_OPT;
    else if (up == pcts_pkg::CH_UP_I) scan_q = SC_I_OPT;
    else if (second && c == pcts_pkg::CH_DOLLAR) scan_q = SC_DOLLAR_OPT;
    else scan_q = SC_PLAIN;
  endfunction

  function automatic void substitute_byte(logic [7:0] c, logic fin);
    pcts_pkg::out_word_t w;
    n_emit = 0;
    case (scan_q)
      SC_ESC: begin
        emit_char(c);
        scan_q = SC_PLAIN;
      end
      SC_PCT: unit_head(c);
      SC_ANGLE_OPT: begin
        if (c == pcts_pkg::CH_LT) begin
          unit_tail(c);
          scan_q = SC_ANGLE;
        end else plain_text(c, fin);
      end
      SC_ARG: begin
        unit_tail(c);
        if (c == pcts_pkg::CH_LT) scan_q = SC_ANGLE;
        else scan_q = SC_PLAIN;
      end
      SC_ANGLE: begin
        unit_tail(c);
        if (c == pcts_pkg::CH_GT) scan_q = SC_PLAIN;
      end
      SC_ALPHA_OPT: begin
        if (is_letter(c)) begin
          unit_tail(c);
          scan_q = SC_PLAIN;
        end else plain_text(c, fin);
      end
      SC_I_OPT: begin
        if (is_num(c) || (dialect_q && upcase(c) == pcts_pkg::CH_UP_L)) begin
          unit_tail(c);
          scan_q = SC_PLAIN;
        end else plain_text(c, fin);
      end
      SC_DOLLAR_OPT: begin
        if (is_num(c) || upcase(c) == pcts_pkg::CH_UP_L) begin
          unit_tail(c);
          scan_q = SC_PLAIN;
        end else plain_text(c, fin);
      end
      default: plain_text(c, fin);
    endcase

    // end of string closes any open unit; an empty last step still marks the end
    if (fin) begin
      scan_q = SC_PLAIN;
      if (n_emit == 0) begin
        w.char_out = 8'h00;
        w.char_valid = 1'b0;
        w.string_end = 1'b1;
        queue_word(w);
      end
    end
    for (int i = 0; i < n_emit; i++) begin
      w.char_out = emitted[i];
      w.char_valid = 1'b1;
      w.string_end = fin && (i == n_emit - 1);
      queue_word(w);
    end
  endfunction

  always @(posedge clk) begin
    pcts_pkg::out_word_t want;
    if (rst) begin
      dialect_q = 1'b0;
      eval_q = 1'b1;
      scan_q = SC_PLAIN;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) substitute_byte(in_word.char_in, in_word.is_final);
      // a write applies from the next accepted byte on
      if (cfg_we) begin
        if (cfg_index == pcts_pkg::CFG_DIALECT) dialect_q = cfg_data;
        else if (cfg_index == pcts_pkg::CFG_EVALUATE) eval_q = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: output word with none expected: char=%h valid=%b end=%b",
                     $time, out_word.char_out, out_word.char_valid, out_word.string_end);
        end else begin
          want = expected_words.pop_front();
          if (out_word.char_out !== want.char_out ||
              out_word.char_valid !== want.char_valid ||
              out_word.string_end !== want.string_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: mismatch: expected char=%h valid=%b end=%b, ",
                        "got char=%h valid=%b end=%b"},
                       $time, want.char_out, want.char_valid, want.string_end,
                       out_word.char_out, out_word.char_valid, out_word.string_end);
          end
        end
      end
    end
    errors <= mismatch_cnt;
    waiting <= expected_words.size();
  end

endmodule

// ===== tb/tb_percent_substitution_pass.sv =====
`timescale 1ns / 1ps
// Testbench top for the percent substitution pass: clock, reset, stimulus and
// verdict. Depends on pcts_pkg, percent_substitution_pass and the checker.
module tb_percent_substitution_pass;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  pcts_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pcts_pkg::out_word_t out_word;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic                cfg_data = 1'b0;
  int                  errors;
  int                  waiting;

  logic       idle_on = 1'b0;
  int         stall_left = 0;
  int         sent_cnt = 0;
  logic [7:0] text [$];

  percent_substitution_pass u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  percent_substitution_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .waiting   (waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls in bursts of random length while idle_on is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #2_000_000;
    $display("tb_percent_substitution_pass: done, errors");
    $finish;
  end

  task automatic add_byte(input logic [7:0] b);
    text.insert(text.size(), b);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] c, input logic fin);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{char_in: c, is_final: fin};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent_cnt++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic load_text(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(input logic dialect, input logic evaluate);
    cfg_we <= 1'b1;
    cfg_index <= pcts_pkg::CFG_DIALECT;
    cfg_data <= dialect;
    @(negedge clk);
    cfg_index <= pcts_pkg::CFG_EVALUATE;
    cfg_data <= evaluate;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_angle_run();
    int n;
    n = $urandom_range(0, 4);
    add_byte(pcts_pkg::CH_LT);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 5) != 0) add_byte(pcts_pkg::CH_GT);
  endtask

  // mostly well-formed units with random content, plus noise and escapes
  task automatic make_random_text();
    string      heads;
    int         n_tok;
    int         kind;
    int         pick;
    logic [7:0] head;
    heads = "%bBtTrR 7QqCcXxVvWw=Ii$";
    text.delete();
    n_tok = $urandom_range(1, 8);
    repeat (n_tok) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        add_byte(8'($urandom_range(0, 255)));
      end else if (kind == 2) begin
        add_byte(pcts_pkg::CH_BSLASH);
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_byte(pcts_pkg::CH_PERCENT);
        pick = $urandom_range(0, heads.len());
        head = (pick == heads.len()) ? 8'($urandom_range(0, 255)) : heads[pick];
        add_byte(head);
        if ($urandom_range(0, 4) != 0) begin
          case (head)
            "Q", "q", "C", "c", "X", "x": begin
              if ($urandom_range(0, 1) != 0) add_angle_run();
              else add_byte(8'($urandom_range(0, 255)));
            end
            "V", "v", "W", "w":
              add_byte(8'(($urandom_range(0, 1) != 0 ? "a" : "A") + $urandom_range(0, 25)));
            "=": add_angle_run();
            "I", "i", "$": begin
              case ($urandom_range(0, 3))
                0: add_byte(pcts_pkg::CH_UP_L);
                1: add_byte("l");
                2: add_byte(8'("0" + $urandom_range(0, 9)));
                default: add_byte(8'($urandom_range(0, 255)));
              endcase
            end
            default: ;
          endcase
        end
      end
    end
  endtask

  initial begin
    int phase;
    int target;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: first dialect, evaluating
    set_config(1'b0, 1'b1);
    load_text("%r");   send_text();
    load_text("%%");   send_text();
    load_text("\\");   send_text();
    load_text("%");    send_text();
    load_text("%Q<a"); send_text();
    load_text("%I5z"); send_text();
    load_text("\\%");  send_text();
    text.delete();
    add_byte(8'h00);
    add_byte(8'hFF);
    send_text();
    wait_drain();
    set_config(1'b1, 1'b1);
    load_text("% ");   send_text();
    load_text("%$L");  send_text();
    wait_drain();

    // random phases across all register settings
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(1'b1, 1'b1);
        1: set_config(1'b0, 1'b0);
        2: set_config(1'b1, 1'b0);
        3: set_config(1'b0, 1'b1);
        default: set_config(1'b1, 1'b1);
      endcase
      target = (phase < 4) ? 20 + 95 * (phase + 1) : 450;
      while (sent_cnt < target) begin
        // last phase runs with no idling
        idle_on = (phase < 4) && ($urandom_range(0, 3) != 0);
        make_random_text();
        send_text();
      end
      idle_on = 1'b0;
      wait_drain();
    end

    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("tb_percent_substitution_pass: done, clean");
    end else begin
      $display("tb_percent_substitution_pass: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pcts_pkg.sv
rtl/percent_substitution_pass.sv
rtl/pcts_checker.sv
tb/percent_substitution_checker.sv
tb/tb_percent_substitution_pass.sv
